/* sv/cecr_pkg.sv */
// cecr_pkg: shared constants and the per-item flag bundle for the
// circle collision response pipeline. No dependencies.
`default_nettype none

package cecr_pkg;

   // radius fields and their sum
   localparam int RADIUS_BITS = 16;
   localparam int RSUM_BITS   = RADIUS_BITS + 1;
   // squared distance and squared radius sum
   localparam int SQ_BITS     = 2 * RSUM_BITS;
   // fractional bits of the projection quotient
   localparam int QUOT_FRAC   = 16;
   // low partial product split of the quotient
   localparam int QLO_BITS    = 32;

   // control bits that travel with each item
   typedef struct packed {
      logic valid;
      logic hit;
      logic qneg;
      logic sx;
      logic sy;
   } flags_type;

endpackage

`default_nettype wire

/* sv/cecr_ifs.sv */
// cecr_req_if / cecr_rsp_if: valid/ready channels for circle pairs and
// resolved velocities. Depends on nothing.
`default_nettype none

interface cecr_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_pos_x;
   logic signed [COORD_BITS-1:0] first_pos_y;
   logic signed [COORD_BITS-1:0] first_vel_x;
   logic signed [COORD_BITS-1:0] first_vel_y;
   logic [15:0]                  first_radius;
   logic signed [COORD_BITS-1:0] second_pos_x;
   logic signed [COORD_BITS-1:0] second_pos_y;
   logic signed [COORD_BITS-1:0] second_vel_x;
   logic signed [COORD_BITS-1:0] second_vel_y;
   logic [15:0]                  second_radius;

   modport source (
      output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
      output second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius,
      input  ready
   );
   modport sink (
      input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
      input  second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius,
      output ready
   );
endinterface

interface cecr_rsp_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] new_first_vel_x;
   logic signed [COORD_BITS-1:0] new_first_vel_y;
   logic signed [COORD_BITS-1:0] new_second_vel_x;
   logic signed [COORD_BITS-1:0] new_second_vel_y;
   logic                         hit;
   logic                         clamped;

   modport source (
      output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
      output hit, clamped,
      input  ready
   );
   modport sink (
      input  valid, new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
      input  hit, clamped,
      output ready
   );
endinterface

`default_nettype wire

/* sv/circle_elastic_collision_response.sv */
// circle_elastic_collision_response: top level of the equal-mass circle
// collision pipeline. Uses cecr_pkg, cecr_ifs, cecr_front, cecr_div, cecr_back.
//
// Usage:
//   req_if carries one circle pair per item: centres, velocities (signed,
//   COORD_BITS wide) and 16-bit radii. rsp_if returns the new velocities
//   with hit (overlap, velocities updated) and clamped (a result saturated).
//   Each item gives exactly one result, in order.
//   Pipeline: between acceptance and rsp_if.valid lie three front stages,
//   one divider stage per quotient bit (COORD_BITS + 34 of them), three
//   multiply/sign stages and the output register.
//   Throughput: one item per cycle, back to back, while the skid entry is empty.
//   Reset (synchronous) empties every stage; payload is not cleared.
//   When rsp_if.ready is low the result holds, one more finished item is
//   parked in a skid entry, and then req_if.ready drops and the whole
//   pipeline holds until the output is taken.
`default_nettype none

module circle_elastic_collision_response #(
   parameter int COORD_BITS = 24
) (
   input wire logic   clock,
   input wire logic   reset,
   cecr_req_if.sink   req_if,
   cecr_rsp_if.source rsp_if
);

   localparam int C  = COORD_BITS;
   localparam int RW = cecr_pkg::RSUM_BITS;
   localparam int SW = cecr_pkg::SQ_BITS;

   logic                en;
   logic                skid_busy;
   cecr_pkg::flags_type fr_flags, dv_flags;
   logic [C+17:0]       fr_adot;
   logic [SW-1:0]       fr_d2;
   logic [RW-1:0]       fr_ax, fr_ay, dv_ax, dv_ay;
   logic [3:0][C-1:0]   fr_vel, dv_vel;
   logic [C+33:0]       dv_quot;

   // the pipeline moves unless the skid entry is occupied
   assign en           = !skid_busy;
   assign req_if.ready = en;

   cecr_front #(.COORD_BITS(C)) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_if.valid),
      .first_pos_x  (req_if.first_pos_x),
      .first_pos_y  (req_if.first_pos_y),
      .first_vel_x  (req_if.first_vel_x),
      .first_vel_y  (req_if.first_vel_y),
      .first_radius (req_if.first_radius),
      .second_pos_x (req_if.second_pos_x),
      .second_pos_y (req_if.second_pos_y),
      .second_vel_x (req_if.second_vel_x),
      .second_vel_y (req_if.second_vel_y),
      .second_radius(req_if.second_radius),
      .out_flags    (fr_flags),
      .out_adot     (fr_adot),
      .out_d2       (fr_d2),
      .out_ax       (fr_ax),
      .out_ay       (fr_ay),
      .out_vel      (fr_vel)
   );

   cecr_div #(.COORD_BITS(C)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_flags (fr_flags),
      .in_adot  (fr_adot),
      .in_d2    (fr_d2),
      .in_ax    (fr_ax),
      .in_ay    (fr_ay),
      .in_vel   (fr_vel),
      .out_flags(dv_flags),
      .out_quot (dv_quot),
      .out_ax   (dv_ax),
      .out_ay   (dv_ay),
      .out_vel  (dv_vel)
   );

   cecr_back #(.COORD_BITS(C)) u_back (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_flags        (dv_flags),
      .in_quot         (dv_quot),
      .in_ax           (dv_ax),
      .in_ay           (dv_ay),
      .in_vel          (dv_vel),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .new_first_vel_x (rsp_if.new_first_vel_x),
      .new_first_vel_y (rsp_if.new_first_vel_y),
      .new_second_vel_x(rsp_if.new_second_vel_x),
      .new_second_vel_y(rsp_if.new_second_vel_y),
      .hit             (rsp_if.hit),
      .clamped         (rsp_if.clamped),
      .skid_busy       (skid_busy)
   );

endmodule

`default_nettype wire

/* sv/cecr_front.sv */
// cecr_front: three stages of differences, overlap test, squares and the
// dot product, ending in the dividend and divisor. Uses cecr_pkg.
`default_nettype none

module cecr_front #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic signed [COORD_BITS-1:0]    first_pos_x,
   input  wire logic signed [COORD_BITS-1:0]    first_pos_y,
   input  wire logic signed [COORD_BITS-1:0]    first_vel_x,
   input  wire logic signed [COORD_BITS-1:0]    first_vel_y,
   input  wire logic [cecr_pkg::RADIUS_BITS-1:0] first_radius,
   input  wire logic signed [COORD_BITS-1:0]    second_pos_x,
   input  wire logic signed [COORD_BITS-1:0]    second_pos_y,
   input  wire logic signed [COORD_BITS-1:0]    second_vel_x,
   input  wire logic signed [COORD_BITS-1:0]    second_vel_y,
   input  wire logic [cecr_pkg::RADIUS_BITS-1:0] second_radius,
   output cecr_pkg::flags_type                  out_flags,
   output logic [COORD_BITS+17:0]               out_adot,
   output logic [cecr_pkg::SQ_BITS-1:0]         out_d2,
   output logic [cecr_pkg::RSUM_BITS-1:0]       out_ax,
   output logic [cecr_pkg::RSUM_BITS-1:0]       out_ay,
   output logic [3:0][COORD_BITS-1:0]           out_vel
);

   localparam int C  = COORD_BITS;
   localparam int RW = cecr_pkg::RSUM_BITS;
   localparam int SW = cecr_pkg::SQ_BITS;

   // stage 1: differences and radius sum
   logic                   s1_valid_ff;
   logic signed [C:0]      dx_in, dy_in, dvx_in, dvy_in;
   logic signed [C:0]      s1_dx_ff, s1_dy_ff, s1_dvx_ff, s1_dvy_ff;
   logic [RW-1:0]          rsum_in, s1_rsum_ff;
   logic [3:0][C-1:0]      s1_vel_ff;

   always_comb begin
      dx_in   = {first_pos_x[C-1], first_pos_x} - {second_pos_x[C-1], second_pos_x};
      dy_in   = {first_pos_y[C-1], first_pos_y} - {second_pos_y[C-1], second_pos_y};
      dvx_in  = {first_vel_x[C-1], first_vel_x} - {second_vel_x[C-1], second_vel_x};
      dvy_in  = {first_vel_y[C-1], first_vel_y} - {second_vel_y[C-1], second_vel_y};
      rsum_in = {1'b0, first_radius} + {1'b0, second_radius};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff   <= dx_in;
         s1_dy_ff   <= dy_in;
         s1_dvx_ff  <= dvx_in;
         s1_dvy_ff  <= dvy_in;
         s1_rsum_ff <= rsum_in;
         s1_vel_ff  <= {second_vel_y, second_vel_x, first_vel_y, first_vel_x};
      end
   end

   // stage 2: magnitudes, per-axis reject, squares and dot terms
   logic                   s2_valid_ff, s2_near_ff, s2_sx_ff, s2_sy_ff;
   logic [C:0]             ax_full, ay_full;
   logic [RW-1:0]          ax_in, ay_in;
   logic signed [RW:0]     dx_nar, dy_nar;
   logic                   near_in;
   logic [SW-1:0]          sqx_in, sqy_in, rsq_in;
   logic signed [C+18:0]   prx_in, pry_in;
   logic [SW-1:0]          s2_sqx_ff, s2_sqy_ff, s2_rsq_ff;
   logic signed [C+18:0]   s2_prx_ff, s2_pry_ff;
   logic [RW-1:0]          s2_ax_ff, s2_ay_ff;
   logic [3:0][C-1:0]      s2_vel_ff;

   always_comb begin
      ax_full = s1_dx_ff[C] ? (~s1_dx_ff + 1'b1) : s1_dx_ff;
      ay_full = s1_dy_ff[C] ? (~s1_dy_ff + 1'b1) : s1_dy_ff;
      near_in = (ax_full < s1_rsum_ff) && (ay_full < s1_rsum_ff);
      // only meaningful when near: then both offsets fit the radius sum
      ax_in   = RW'(ax_full);
      ay_in   = RW'(ay_full);
      dx_nar  = (RW+1)'(s1_dx_ff);
      dy_nar  = (RW+1)'(s1_dy_ff);
      sqx_in  = ax_in * ax_in;
      sqy_in  = ay_in * ay_in;
      rsq_in  = s1_rsum_ff * s1_rsum_ff;
      prx_in  = dx_nar * s1_dvx_ff;
      pry_in  = dy_nar * s1_dvy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_near_ff <= near_in;
         s2_sx_ff   <= s1_dx_ff[C];
         s2_sy_ff   <= s1_dy_ff[C];
         s2_sqx_ff  <= sqx_in;
         s2_sqy_ff  <= sqy_in;
         s2_rsq_ff  <= rsq_in;
         s2_prx_ff  <= prx_in;
         s2_pry_ff  <= pry_in;
         s2_ax_ff   <= ax_in;
         s2_ay_ff   <= ay_in;
         s2_vel_ff  <= s1_vel_ff;
      end
   end

   // stage 3: squared distance, overlap decision, dot magnitude
   logic [SW:0]            d2_sum;
   logic signed [C+19:0]   dot_s;
   logic [C+19:0]          adot_w;
   cecr_pkg::flags_type    flags_in, s3_flags_ff;
   logic [C+17:0]          s3_adot_ff;
   logic [SW-1:0]          s3_d2_ff;
   logic [RW-1:0]          s3_ax_ff, s3_ay_ff;
   logic [3:0][C-1:0]      s3_vel_ff;

   always_comb begin
      d2_sum         = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
      dot_s          = (C+20)'(s2_prx_ff) + (C+20)'(s2_pry_ff);
      adot_w         = dot_s[C+19] ? (~dot_s + 1'b1) : dot_s;
      flags_in.valid = s2_valid_ff;
      flags_in.hit   = s2_near_ff && (d2_sum != '0) && (d2_sum < {1'b0, s2_rsq_ff});
      flags_in.qneg  = dot_s[C+19];
      flags_in.sx    = s2_sx_ff;
      flags_in.sy    = s2_sy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_flags_ff <= '0;
      end else if (en) begin
         s3_flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_adot_ff  <= adot_w[C+17:0];
         s3_d2_ff    <= d2_sum[SW-1:0];
         s3_ax_ff    <= s2_ax_ff;
         s3_ay_ff    <= s2_ay_ff;
         s3_vel_ff   <= s2_vel_ff;
      end
   end

   assign out_flags = s3_flags_ff;
   assign out_adot  = s3_adot_ff;
   assign out_d2    = s3_d2_ff;
   assign out_ax    = s3_ax_ff;
   assign out_ay    = s3_ay_ff;
   assign out_vel   = s3_vel_ff;

endmodule

`default_nettype wire

/* sv/cecr_div.sv */
// cecr_div: pipelined restoring divider, one quotient bit per stage,
// forming |dot| * 2^16 / |d|^2. Uses cecr_pkg.
`default_nettype none

module cecr_div #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  cecr_pkg::flags_type                  in_flags,
   input  wire logic [COORD_BITS+17:0]          in_adot,
   input  wire logic [cecr_pkg::SQ_BITS-1:0]    in_d2,
   input  wire logic [cecr_pkg::RSUM_BITS-1:0]  in_ax,
   input  wire logic [cecr_pkg::RSUM_BITS-1:0]  in_ay,
   input  wire logic [3:0][COORD_BITS-1:0]      in_vel,
   output cecr_pkg::flags_type                  out_flags,
   output logic [COORD_BITS+33:0]               out_quot,
   output logic [cecr_pkg::RSUM_BITS-1:0]       out_ax,
   output logic [cecr_pkg::RSUM_BITS-1:0]       out_ay,
   output logic [3:0][COORD_BITS-1:0]           out_vel
);

   localparam int C  = COORD_BITS;
   localparam int NB = COORD_BITS + 18 + cecr_pkg::QUOT_FRAC;
   localparam int RW = cecr_pkg::RSUM_BITS;
   localparam int SW = cecr_pkg::SQ_BITS;

   // stage registers; num shifts dividend bits out and quotient bits in
   cecr_pkg::flags_type flg_ff [NB];
   logic [NB-1:0]       num_ff [NB];
   logic [SW-1:0]       rem_ff [NB];
   logic [SW-1:0]       d2_ff  [NB];
   logic [RW-1:0]       ax_ff  [NB];
   logic [RW-1:0]       ay_ff  [NB];
   logic [3:0][C-1:0]   vel_ff [NB];

   for (genvar i = 0; i < NB; i++) begin : g_stage
      cecr_pkg::flags_type f_s;
      logic [NB-1:0]       n_s;
      logic [SW-1:0]       r_s, d_s;
      logic [RW-1:0]       ax_s, ay_s;
      logic [3:0][C-1:0]   v_s;
      logic [SW:0]         trial;
      logic                take;
      logic [SW-1:0]       rem_in;
      logic [NB-1:0]       num_in;

      if (i == 0) begin : g_head
         assign f_s  = in_flags;
         assign n_s  = {in_adot, {cecr_pkg::QUOT_FRAC{1'b0}}};
         assign r_s  = '0;
         assign d_s  = in_d2;
         assign ax_s = in_ax;
         assign ay_s = in_ay;
         assign v_s  = in_vel;
      end else begin : g_body
         assign f_s  = flg_ff[i-1];
         assign n_s  = num_ff[i-1];
         assign r_s  = rem_ff[i-1];
         assign d_s  = d2_ff[i-1];
         assign ax_s = ax_ff[i-1];
         assign ay_s = ay_ff[i-1];
         assign v_s  = vel_ff[i-1];
      end

      // bring down one dividend bit, subtract the divisor if it fits
      always_comb begin
         trial  = {r_s, n_s[NB-1]};
         take   = (trial >= {1'b0, d_s});
         rem_in = take ? SW'(trial - {1'b0, d_s}) : trial[SW-1:0];
         num_in = {n_s[NB-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            flg_ff[i] <= '0;
         end else if (en) begin
            flg_ff[i] <= f_s;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i] <= num_in;
            rem_ff[i] <= rem_in;
            d2_ff[i]  <= d_s;
            ax_ff[i]  <= ax_s;
            ay_ff[i]  <= ay_s;
            vel_ff[i] <= v_s;
         end
      end
   end

   assign out_flags = flg_ff[NB-1];
   assign out_quot  = num_ff[NB-1];
   assign out_ax    = ax_ff[NB-1];
   assign out_ay    = ay_ff[NB-1];
   assign out_vel   = vel_ff[NB-1];

endmodule

`default_nettype wire

/* sv/cecr_back.sv */
// cecr_back: projection multiply in split partial products, velocity
// update with saturation, output register and skid entry. Uses cecr_pkg.
`default_nettype none

module cecr_back #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  cecr_pkg::flags_type                  in_flags,
   input  wire logic [COORD_BITS+33:0]          in_quot,
   input  wire logic [cecr_pkg::RSUM_BITS-1:0]  in_ax,
   input  wire logic [cecr_pkg::RSUM_BITS-1:0]  in_ay,
   input  wire logic [3:0][COORD_BITS-1:0]      in_vel,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [COORD_BITS-1:0]         new_first_vel_x,
   output logic signed [COORD_BITS-1:0]         new_first_vel_y,
   output logic signed [COORD_BITS-1:0]         new_second_vel_x,
   output logic signed [COORD_BITS-1:0]         new_second_vel_y,
   output logic                                 hit,
   output logic                                 clamped,
   output logic                                 skid_busy
);

   localparam int C   = COORD_BITS;
   localparam int NB  = COORD_BITS + 18 + cecr_pkg::QUOT_FRAC;
   localparam int RW  = cecr_pkg::RSUM_BITS;
   localparam int QL  = cecr_pkg::QLO_BITS;
   localparam int LOW = QL + RW;
   localparam int HIW = NB - QL + RW;
   localparam int FW  = NB + RW;
   localparam int MW  = C + 2;
   localparam logic signed [C+3:0] SAT_HI = {5'b00000, {(C-1){1'b1}}};
   localparam logic signed [C+3:0] SAT_LO = {5'b11111, {(C-1){1'b0}}};

   typedef struct packed {
      logic [C-1:0] n1x;
      logic [C-1:0] n1y;
      logic [C-1:0] n2x;
      logic [C-1:0] n2y;
      logic         hit;
      logic         clamped;
   } rsp_type;

   // clip to the coordinate range, top bit reports a clip
   function automatic logic [C:0] sat(input logic signed [C+3:0] v);
      logic [C:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, SAT_HI[C-1:0]};
      end else if (v < SAT_LO) begin
         r = {1'b1, SAT_LO[C-1:0]};
      end else begin
         r = {1'b0, v[C-1:0]};
      end
      return r;
   endfunction

   // b1: quotient times offset magnitude, split in low and high parts
   cecr_pkg::flags_type b1_flg_ff;
   logic [LOW-1:0]      b1_plo_x_ff, b1_plo_y_ff;
   logic [HIW-1:0]      b1_phi_x_ff, b1_phi_y_ff;
   logic [3:0][C-1:0]   b1_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_flg_ff <= '0;
      end else if (en) begin
         b1_flg_ff <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_plo_x_ff <= in_quot[QL-1:0] * in_ax;
         b1_plo_y_ff <= in_quot[QL-1:0] * in_ay;
         b1_phi_x_ff <= in_quot[NB-1:QL] * in_ax;
         b1_phi_y_ff <= in_quot[NB-1:QL] * in_ay;
         b1_vel_ff   <= in_vel;
      end
   end

   // b2: merge partial products and drop the quotient fraction
   cecr_pkg::flags_type b2_flg_ff;
   logic [FW-1:0]       full_x, full_y;
   logic [MW-1:0]       b2_mx_ff, b2_my_ff;
   logic [3:0][C-1:0]   b2_vel_ff;

   always_comb begin
      full_x = {b1_phi_x_ff, {QL{1'b0}}} + FW'(b1_plo_x_ff);
      full_y = {b1_phi_y_ff, {QL{1'b0}}} + FW'(b1_plo_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_flg_ff <= '0;
      end else if (en) begin
         b2_flg_ff <= b1_flg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b2_mx_ff  <= full_x[cecr_pkg::QUOT_FRAC +: MW];
         b2_my_ff  <= full_y[cecr_pkg::QUOT_FRAC +: MW];
         b2_vel_ff <= b1_vel_ff;
      end
   end

   // b3: apply the projection sign
   cecr_pkg::flags_type b3_flg_ff;
   logic signed [C+2:0] mag_x, mag_y;
   logic signed [C+2:0] b3_px_ff, b3_py_ff;
   logic [3:0][C-1:0]   b3_vel_ff;

   always_comb begin
      mag_x = (C+3)'(b2_mx_ff);
      mag_y = (C+3)'(b2_my_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_flg_ff <= '0;
      end else if (en) begin
         b3_flg_ff <= b2_flg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b3_px_ff  <= (b2_flg_ff.qneg ^ b2_flg_ff.sx) ? -mag_x : mag_x;
         b3_py_ff  <= (b2_flg_ff.qneg ^ b2_flg_ff.sy) ? -mag_y : mag_y;
         b3_vel_ff <= b2_vel_ff;
      end
   end

   // b4: update, saturate and select the result
   logic signed [C+3:0] sum1x, sum1y, sum2x, sum2y;
   logic [C:0]          sat1x, sat1y, sat2x, sat2y;
   rsp_type             res_in;
   logic                produce;

   always_comb begin
      sum1x = (C+4)'($signed(b3_vel_ff[0])) - (C+4)'(b3_px_ff);
      sum1y = (C+4)'($signed(b3_vel_ff[1])) - (C+4)'(b3_py_ff);
      sum2x = (C+4)'($signed(b3_vel_ff[2])) + (C+4)'(b3_px_ff);
      sum2y = (C+4)'($signed(b3_vel_ff[3])) + (C+4)'(b3_py_ff);
      sat1x = sat(sum1x);
      sat1y = sat(sum1y);
      sat2x = sat(sum2x);
      sat2y = sat(sum2y);
      if (b3_flg_ff.hit) begin
         res_in.n1x     = sat1x[C-1:0];
         res_in.n1y     = sat1y[C-1:0];
         res_in.n2x     = sat2x[C-1:0];
         res_in.n2y     = sat2y[C-1:0];
         res_in.hit     = 1'b1;
         res_in.clamped = sat1x[C] | sat1y[C] | sat2x[C] | sat2y[C];
      end else begin
         res_in.n1x     = b3_vel_ff[0];
         res_in.n1y     = b3_vel_ff[1];
         res_in.n2x     = b3_vel_ff[2];
         res_in.n2y     = b3_vel_ff[3];
         res_in.hit     = 1'b0;
         res_in.clamped = 1'b0;
      end
      produce = en && b3_flg_ff.valid;
   end

   // output register with one skid entry behind it
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (produce) begin
         if (out_valid_ff && !rsp_ready) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (produce) begin
         if (out_valid_ff && !rsp_ready) begin
            skid_data_ff <= res_in;
         end else begin
            out_data_ff <= res_in;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign new_first_vel_x  = out_data_ff.n1x;
   assign new_first_vel_y  = out_data_ff.n1y;
   assign new_second_vel_x = out_data_ff.n2x;
   assign new_second_vel_y = out_data_ff.n2y;
   assign hit              = out_data_ff.hit;
   assign clamped          = out_data_ff.clamped;
   assign skid_busy        = skid_valid_ff;

endmodule

`default_nettype wire

/* sv/cecr_checker.sv */
// cecr_checker: port-level assertions for the collision pipeline, bound
// to circle_elastic_collision_response. Depends on nothing else.
`default_nettype none

module cecr_checker #(
   parameter int COORD_BITS = 24
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_n1x,
   input wire logic [COORD_BITS-1:0] rsp_n1y,
   input wire logic [COORD_BITS-1:0] rsp_n2x,
   input wire logic [COORD_BITS-1:0] rsp_n2y,
   input wire logic                  rsp_hit,
   input wire logic                  rsp_clamped
);

   // reset drains the output
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_n1x, rsp_n1y, rsp_n2x, rsp_n2y, rsp_hit, rsp_clamped}))
      else $error("stalled result changed");

   // back-pressure only after a result was refused
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && $past(rsp_valid && !rsp_ready))
      else $error("input stalled without a refused result");

   // saturation is only possible on a collision
   a_clamp_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> !rsp_clamped)
      else $error("clamped set without hit");

endmodule

bind circle_elastic_collision_response cecr_checker #(.COORD_BITS(COORD_BITS)) u_cecr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_n1x    (rsp_if.new_first_vel_x),
   .rsp_n1y    (rsp_if.new_first_vel_y),
   .rsp_n2x    (rsp_if.new_second_vel_x),
   .rsp_n2y    (rsp_if.new_second_vel_y),
   .rsp_hit    (rsp_if.hit),
   .rsp_clamped(rsp_if.clamped)
);

`default_nettype wire

/* sim/tb_top.sv */
// tb_top: self-checking bench for circle_elastic_collision_response.
// Uses cecr_ifs and the block; predicts each result and compares in order.
`default_nettype none

module tb_top;

   localparam int CB = 24;
   localparam int LATENCY = CB + 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      coord_type p1x, p1y, v1x, v1y;
      logic [15:0] r1;
      coord_type p2x, p2y, v2x, v2y;
      logic [15:0] r2;
   } pair_type;

   typedef struct packed {
      coord_type n1x, n1y, n2x, n2y;
      logic hit;
      logic clamped;
   } velocities_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned cycles = 0;
   int errors = 0;
   bit hold_off = 1'b0;
   bit ready_free = 1'b0;

   velocities_type pending_velocities[$];

   cecr_req_if #(.COORD_BITS(CB)) req_if ();
   cecr_rsp_if #(.COORD_BITS(CB)) rsp_if ();

   circle_elastic_collision_response #(.COORD_BITS(CB)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // clock and cycle limit
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // saturate to the coordinate range
   function automatic longint clip(longint v, ref bit clamp);
      longint hi, lo;
      hi = (longint'(1) <<< (CB - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clamp = 1;
         return hi;
      end
      if (v < lo) begin
         clamp = 1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint proj(longint unsigned q, bit qneg, longint d);
      longint unsigned m;
      m = (q * longint'(d < 0 ? -d : d)) >> 16;
      return (qneg != (d < 0)) ? -longint'(m) : longint'(m);
   endfunction

   // expected velocities for one circle pair
   function automatic velocities_type resolve_pair(pair_type p);
      velocities_type res;
      longint dx, dy, dvx, dvy, dot, px, py;
      longint unsigned ax, ay, rsum, d2, adot, q;
      bit hit, clamp;
      dx = longint'(p.p1x) - longint'(p.p2x);
      dy = longint'(p.p1y) - longint'(p.p2y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      rsum = longint'(p.r1) + longint'(p.r2);
      hit = 0;
      clamp = 0;
      d2 = 0;
      res.n1x = p.v1x;
      res.n1y = p.v1y;
      res.n2x = p.v2x;
      res.n2y = p.v2y;
      if (ax < rsum && ay < rsum) begin
         d2 = ax * ax + ay * ay;
         if (d2 != 0 && d2 < rsum * rsum) hit = 1;
      end
      if (hit) begin
         dvx = longint'(p.v1x) - longint'(p.v2x);
         dvy = longint'(p.v1y) - longint'(p.v2y);
         dot = dx * dvx + dy * dvy;
         adot = dot < 0 ? -dot : dot;
         q = ((adot / d2) << 16) + (((adot % d2) << 16) / d2);
         px = proj(q, dot < 0, dx);
         py = proj(q, dot < 0, dy);
         res.n1x = coord_type'(clip(longint'(p.v1x) - px, clamp));
         res.n1y = coord_type'(clip(longint'(p.v1y) - py, clamp));
         res.n2x = coord_type'(clip(longint'(p.v2x) + px, clamp));
         res.n2y = coord_type'(clip(longint'(p.v2y) + py, clamp));
      end
      res.hit = hit;
      res.clamped = clamp;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
   endtask

   // receiver stall pattern, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_off) begin
         rsp_if.ready <= 1'b0;
      end else if (ready_free) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ((cycles % 23) < 15) ? ($urandom_range(0, 3) != 0)
                                              : ($urandom_range(0, 1) != 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      velocities_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_velocities.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
         end else begin
            w = pending_velocities.pop_front();
            if (rsp_if.new_first_vel_x !== w.n1x)
               report_mismatch("new_first_vel_x", rsp_if.new_first_vel_x, w.n1x);
            if (rsp_if.new_first_vel_y !== w.n1y)
               report_mismatch("new_first_vel_y", rsp_if.new_first_vel_y, w.n1y);
            if (rsp_if.new_second_vel_x !== w.n2x)
               report_mismatch("new_second_vel_x", rsp_if.new_second_vel_x, w.n2x);
            if (rsp_if.new_second_vel_y !== w.n2y)
               report_mismatch("new_second_vel_y", rsp_if.new_second_vel_y, w.n2y);
            if (rsp_if.hit !== w.hit) report_mismatch("hit", rsp_if.hit, w.hit);
            if (rsp_if.clamped !== w.clamped)
               report_mismatch("clamped", rsp_if.clamped, w.clamped);
         end
      end
   end

   // offer one pair and wait for it to be taken
   task automatic send_pair(pair_type p);
      req_if.valid <= 1'b1;
      {req_if.first_pos_x, req_if.first_pos_y, req_if.first_vel_x, req_if.first_vel_y,
       req_if.first_radius, req_if.second_pos_x, req_if.second_pos_y,
       req_if.second_vel_x, req_if.second_vel_y, req_if.second_radius} <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_velocities = {pending_velocities, resolve_pair(p)};
   endtask

   task automatic idle_sender(int n);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_results();
      while (pending_velocities.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   // nearby pair, usually overlapping, with random content around a random spot
   function automatic pair_type close_pair(int unsigned spread, int unsigned vel_bits);
      pair_type p;
      longint cx, cy;
      cx = longint'($signed($urandom_range(0, 2000000))) - 1000000;
      cy = longint'($signed($urandom_range(0, 2000000))) - 1000000;
      p.r1 = 16'($urandom_range(1, 65535));
      p.r2 = 16'($urandom_range(0, 65535));
      p.p1x = coord_type'(cx);
      p.p1y = coord_type'(cy);
      p.p2x = coord_type'(cx + longint'($urandom_range(0, 2 * spread)) - spread);
      p.p2y = coord_type'(cy + longint'($urandom_range(0, 2 * spread)) - spread);
      p.v1x = coord_type'($signed($urandom) >>> (32 - vel_bits));
      p.v1y = coord_type'($signed($urandom) >>> (32 - vel_bits));
      p.v2x = coord_type'($signed($urandom) >>> (32 - vel_bits));
      p.v2y = coord_type'($signed($urandom) >>> (32 - vel_bits));
      return p;
   endfunction

   function automatic pair_type noise_pair();
      pair_type p;
      p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), 16'($urandom),
           rand_coord(), rand_coord(), rand_coord(), rand_coord(), 16'($urandom)};
      return p;
   endfunction

   // extremes, coincident centres, zero radii, one-axis separation
   task automatic test_directed();
      pair_type p;
      coord_type mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      // no overlap, extreme velocities pass through
      send_pair({mx, mx, mx, mn, 16'hFFFF, mn, mn, mn, mx, 16'hFFFF});
      send_pair({mn, mn, mn, mx, 16'h0000, mx, mx, mx, mn, 16'h0000});
      // coincident centres
      send_pair({coord_type'(100), coord_type'(100), mx, mn, 16'hFFFF,
                 coord_type'(100), coord_type'(100), mn, mx, 16'hFFFF});
      // both radii zero with nearby centres
      send_pair({coord_type'(0), coord_type'(0), coord_type'(5), coord_type'(0), 16'h0,
                 coord_type'(1), coord_type'(0), coord_type'(-5), coord_type'(0), 16'h0});
      // head-on along x
      send_pair({coord_type'(0), coord_type'(0), coord_type'(256), coord_type'(0), 16'h0100,
                 coord_type'(256), coord_type'(0), coord_type'(-256), coord_type'(0),
                 16'h0100});
      // far on one axis only
      send_pair({coord_type'(0), coord_type'(0), coord_type'(9), coord_type'(9), 16'h0080,
                 coord_type'(512), coord_type'(1), coord_type'(-9), coord_type'(3), 16'h0080});
      // distance exactly the radius sum
      send_pair({coord_type'(0), coord_type'(0), coord_type'(9), coord_type'(9), 16'h0100,
                 coord_type'(512), coord_type'(0), coord_type'(-9), coord_type'(3), 16'h0100});
      // overlapping with extreme velocities
      send_pair({coord_type'(0), coord_type'(0), mx, mx, 16'hFFFF,
                 coord_type'(1), coord_type'(1), mn, mn, 16'hFFFF});
      send_pair({coord_type'(0), coord_type'(0), mn, mn, 16'hFFFF,
                 coord_type'(-1), coord_type'(1), mx, mx, 16'hFFFF});
      send_pair({coord_type'(0), coord_type'(0), mn, mx, 16'hFFFF,
                 coord_type'(1), coord_type'(-1), mx, mn, 16'hFFFF});
      // large radii near both far corners, tiny and wide offsets
      send_pair({mn, mx, coord_type'(-1), coord_type'(1), 16'hFFFF,
                 coord_type'(mn + 3), coord_type'(mx - 7), coord_type'(1), coord_type'(-1),
                 16'h0001});
      send_pair({mx, mn, coord_type'(0), coord_type'(0), 16'hFFFF,
                 coord_type'(mx - 65535), coord_type'(mn + 65535), coord_type'(0),
                 coord_type'(-1), 16'hFFFF});
      for (int i = 0; i < 8; i++) begin
         p = noise_pair();
         send_pair(p);
      end
      idle_sender(1);
   endtask

   // bursty random traffic, mostly overlapping pairs
   task automatic test_random(int n);
      int burst;
      int sent;
      pair_type p;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && sent < n; i++) begin
            case ($urandom_range(0, 9))
               0, 1: p = noise_pair();
               2: p = close_pair(2000, 32);
               3, 4: p = close_pair(200, 14);
               default: p = close_pair(60000, 20);
            endcase
            send_pair(p);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
      idle_sender(1);
   endtask

   // long receiver hold-off while the sender keeps offering, then full drain
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 120; i++) send_pair(close_pair(500, 16));
            idle_sender(1);
         end
      join
      drain_results();
   endtask

   // receiver always ready, sender back to back
   task automatic test_streaming();
      ready_free = 1'b1;
      for (int i = 0; i < 100; i++) send_pair(close_pair(3000, 18));
      idle_sender(1);
      drain_results();
      ready_free = 1'b0;
   endtask

   initial begin
      req_if.valid <= 1'b0;
      {req_if.first_pos_x, req_if.first_pos_y, req_if.first_vel_x, req_if.first_vel_y,
       req_if.first_radius, req_if.second_pos_x, req_if.second_pos_y,
       req_if.second_vel_x, req_if.second_vel_y, req_if.second_radius} <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      test_backpressure();
      test_streaming();
      test_random(300);
      drain_results();
      repeat (2 * LATENCY) @(posedge clock);
      if (errors == 0 && pending_velocities.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
sv/cecr_pkg.sv
sv/cecr_ifs.sv
sv/cecr_front.sv
sv/cecr_div.sv
sv/cecr_back.sv
sv/circle_elastic_collision_response.sv
sv/cecr_checker.sv
sim/tb_top.sv
